// ----- hw/rtl/tag_length_packet_deframer_top_macros.svh -----
// assertion macros shared by the deframer rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef TAG_LENGTH_PACKET_DEFRAMER_TOP_MACROS_SVH
`define TAG_LENGTH_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define TLPD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define TLPD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TLPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TLPD_ASSERT_ALWAYS(label, expr, msg)
`define TLPD_ASSERT_IMPLIES(label, ante, cons, msg)
`define TLPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/tlpd_pkg.sv -----
// types, codes and tag table for the tag-length packet deframer
// no dependencies
package tlpd_pkg;

	localparam int MAX_PACKET_DEF = 11;

	// parser phases
	localparam logic [1:0] PH_TAG  = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SKIP = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_KEY      = 3'd0;
	localparam logic [2:0] KIND_VERSION  = 3'd1;
	localparam logic [2:0] KIND_TIME     = 3'd2;
	localparam logic [2:0] KIND_WAKEUP   = 3'd3;
	localparam logic [2:0] KIND_RESPONSE = 3'd4;
	localparam logic [2:0] KIND_BAD_TAG  = 3'd5;
	localparam logic [2:0] KIND_BAD_LEN  = 3'd6;

	// known tags
	localparam logic [7:0] TAG_KEY      = 8'hF1;
	localparam logic [7:0] TAG_VERSION  = 8'hDB;
	localparam logic [7:0] TAG_TIME     = 8'hFC;
	localparam logic [7:0] TAG_WAKEUP   = 8'hE7;
	localparam logic [7:0] TAG_RESPONSE = 8'hC5;

	typedef struct packed {
		logic       known;
		logic [3:0] total;
		logic [2:0] kind;
	} tag_info_t;

	function automatic tag_info_t tag_lookup(input logic [7:0] tag);
		tag_info_t info;
		info = '0;
		unique case (tag)
			TAG_KEY: begin
				info = '{known: 1'b1, total: 4'd3, kind: KIND_KEY};
			end
			TAG_VERSION: begin
				info = '{known: 1'b1, total: 4'd6, kind: KIND_VERSION};
			end
			TAG_TIME: begin
				info = '{known: 1'b1, total: 4'd11, kind: KIND_TIME};
			end
			TAG_WAKEUP: begin
				info = '{known: 1'b1, total: 4'd10, kind: KIND_WAKEUP};
			end
			TAG_RESPONSE: begin
				info = '{known: 1'b1, total: 4'd3, kind: KIND_RESPONSE};
			end
			default: begin
				info = '{known: 1'b0, total: 4'd0, kind: KIND_KEY};
			end
		endcase
		return info;
	endfunction

endpackage

// ----- hw/rtl/tag_length_packet_deframer_top.sv -----
// top level of the tag-length packet deframer
// depends on tlpd_pkg, tlpd_ram and the assertion macro header
//
// Takes one received serial byte per word on the input channel and returns each complete
// tag-length-payload packet as one result word per byte (tag first, with kind, index and
// last mark), or a single error word for an unknown tag or a wrong length byte. A byte is
// registered on entry and parsed in the next cycle, so the input takes one byte every cycle.
// A finished packet is read back from a double-banked packet ram one byte per unstalled cycle,
// in 3 to 11 result words per packet; the next packet is assembled in the other bank meanwhile.
// A byte that would produce a result while the previous packet is still being delivered waits
// in the input register, stalling the input, until the last result of that packet is taken.
`include "tag_length_packet_deframer_top_macros.svh"

module tag_length_packet_deframer_top
	import tlpd_pkg::*;
#(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] packet_kind,
	output logic [7:0] out_byte,
	output logic [3:0] byte_index,
	output logic       last
);

	localparam int IDX_W  = $clog2(MAX_PACKET);
	localparam int ADDR_W = IDX_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	// input register
	logic       s1_valid_s1;
	logic [7:0] s1_byte_s1;

	// parser state
	logic [1:0] phase_q;
	logic [7:0] current_tag_q;
	logic [3:0] exp_total_q;
	logic [3:0] byte_count_q;
	logic [7:0] skip_q;
	logic       wr_bank_q;

	// emitter state
	logic       out_valid_q;
	logic       out_err_q;
	logic [2:0] out_kind_q;
	logic [3:0] out_idx_q;
	logic [3:0] out_total_q;
	logic       rd_bank_q;

	tag_info_t  in_info;
	tag_info_t  cur_info;
	logic       bad_tag;
	logic       len_ok;
	logic [3:0] count_inc;
	logic       pkt_done;
	logic       needs_emit;
	logic       err_res;
	logic [2:0] res_kind;
	logic       emit_free;
	logic       s1_adv;
	logic       s1_fire;
	logic       emit_load;
	logic       out_take;
	logic       last_o;

	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [7:0]        ram_rd_data;

	always_comb begin
		in_info   = tag_lookup(s1_byte_s1);
		cur_info  = tag_lookup(current_tag_q);
		bad_tag   = !in_info.known || (int'(in_info.total) > MAX_PACKET);
		len_ok    = (({1'b0, s1_byte_s1} + 9'd2) == {5'd0, exp_total_q});
		count_inc = byte_count_q + 4'd1;
		pkt_done  = (count_inc >= exp_total_q);

		needs_emit = 1'b0;
		err_res    = 1'b0;
		res_kind   = cur_info.kind;
		unique case (phase_q)
			PH_TAG: begin
				needs_emit = bad_tag;
				err_res    = 1'b1;
				res_kind   = KIND_BAD_TAG;
			end
			PH_LEN: begin
				needs_emit = !len_ok;
				err_res    = 1'b1;
				res_kind   = KIND_BAD_LEN;
			end
			PH_DATA: begin
				needs_emit = pkt_done;
			end
			PH_SKIP: begin
				needs_emit = 1'b0;
			end
			default: begin
				needs_emit = 1'b0;
			end
		endcase
	end

	assign last_o    = out_err_q || ((out_idx_q + 4'd1) == out_total_q);
	assign out_take  = out_valid_q && !out_stall;
	assign emit_free = !out_valid_q || (out_take && last_o);
	assign s1_adv    = !needs_emit || emit_free;
	assign s1_fire   = s1_valid_s1 && s1_adv;
	assign emit_load = s1_fire && needs_emit;
	assign in_stall  = s1_valid_s1 && !s1_adv;

	// packet bytes go into the bank being assembled
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = {wr_bank_q, IDX_W'(byte_count_q)};
		unique case (phase_q)
			PH_TAG: begin
				ram_wr_en   = s1_fire && !bad_tag;
				ram_wr_addr = {wr_bank_q, {IDX_W{1'b0}}};
			end
			PH_LEN: begin
				ram_wr_en   = s1_fire && len_ok;
				ram_wr_addr = {wr_bank_q, IDX_W'(1)};
			end
			PH_DATA: begin
				ram_wr_en = s1_fire;
			end
			PH_SKIP: begin
				ram_wr_en = 1'b0;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	// read index 0 of the finished bank on load, then one byte ahead per taken word
	assign ram_rd_en   = (emit_load && !err_res) || (out_take && !last_o);
	assign ram_rd_addr = emit_load ? {wr_bank_q, {IDX_W{1'b0}}}
		: {rd_bank_q, IDX_W'(out_idx_q + 4'd1)};

	tlpd_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (s1_byte_s1),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			s1_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			current_tag_q <= 8'd0;
			exp_total_q   <= 4'd0;
			byte_count_q  <= 4'd0;
			skip_q        <= 8'd0;
			wr_bank_q     <= 1'b0;
		end else if (s1_fire) begin
			unique case (phase_q)
				PH_TAG: begin
					if (bad_tag) begin
						current_tag_q <= 8'd0;
					end else begin
						current_tag_q <= s1_byte_s1;
						exp_total_q   <= in_info.total;
						byte_count_q  <= 4'd1;
						phase_q       <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (len_ok) begin
						byte_count_q <= 4'd2;
						phase_q      <= PH_DATA;
					end else begin
						skip_q       <= s1_byte_s1;
						byte_count_q <= 4'd0;
						phase_q      <= (s1_byte_s1 == 8'd0) ? PH_TAG : PH_SKIP;
					end
				end
				PH_DATA: begin
					if (pkt_done) begin
						byte_count_q <= 4'd0;
						phase_q      <= PH_TAG;
						wr_bank_q    <= !wr_bank_q;
					end else begin
						byte_count_q <= count_inc;
					end
				end
				PH_SKIP: begin
					if (skip_q <= 8'd1) begin
						phase_q <= PH_TAG;
					end
					if (skip_q != 8'd0) begin
						skip_q <= skip_q - 8'd1;
					end
				end
				default: begin
					phase_q <= PH_TAG;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_err_q   <= 1'b0;
			out_kind_q  <= KIND_KEY;
			out_idx_q   <= 4'd0;
			out_total_q <= 4'd0;
			rd_bank_q   <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
			out_err_q   <= err_res;
			out_kind_q  <= res_kind;
			out_idx_q   <= 4'd0;
			out_total_q <= exp_total_q;
			rd_bank_q   <= wr_bank_q;
		end else if (out_take) begin
			if (last_o) begin
				out_valid_q <= 1'b0;
			end else begin
				out_idx_q <= out_idx_q + 4'd1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_kind = out_kind_q;
	assign out_byte    = out_err_q ? 8'd0 : ram_rd_data;
	assign byte_index  = out_idx_q;
	assign last        = last_o;

	`TLPD_ASSERT_ALWAYS(a_skip_nonzero, phase_q != PH_SKIP || skip_q != 8'd0, "skip phase with zero count")
	`TLPD_ASSERT_IMPLIES(a_data_count, phase_q == PH_DATA, byte_count_q >= 4'd2 && byte_count_q < exp_total_q, "payload count out of range")
	`TLPD_ASSERT_IMPLIES(a_emit_idx, out_valid_q && !out_err_q, out_idx_q < out_total_q, "result index beyond packet")
	`TLPD_ASSERT_IMPLIES(a_bank_split, out_valid_q && !out_err_q, rd_bank_q != wr_bank_q, "read and write bank collide")
	`TLPD_ASSERT_NEXT(a_s1_hold, in_stall, s1_valid_s1 && $stable(s1_byte_s1), "stalled input byte lost")

endmodule

// ----- hw/rtl/tlpd_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module tlpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
